// ===== design/matrix3_inverse_macros.svh =====
// Assertion macros for the matrix inverse block.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

`ifndef SYNTHESIS

`define MI3_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("matrix3_inverse: check failed");

`define MI3_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("matrix3_inverse: implication failed");

`else

`define MI3_ASSERT(label, prop)

`define MI3_ASSERT_IMP(label, pre, post)

`endif

`endif

// ===== design/mi3_pkg.sv =====
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ENTRIES    = 9;
  localparam int NUM_COLS       = 3;

  // tuser bit positions on the result side
  localparam int USER_SINGULAR = 0;
  localparam int USER_OVF      = 1;
  localparam int USER_WIDTH    = 2;

  // adj[i] = a[PA]*a[PB] - a[QA]*a[QB], row-major entry order
  localparam int ADJ_PA [NUM_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_PB [NUM_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_QA [NUM_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_QB [NUM_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

// ===== design/matrix3_inverse.sv =====
// Channel   Dir  tdata (low bit up)                     tuser
// s_axis    in   a11 a12 a13 a21 a22 a23 a31 a32 a33    -
// m_axis    out  b11 b12 b13 b21 b22 b23 b31 b32 b33    singular, overflowed
//
// One matrix per cycle while m_axis_tready holds; stages: product, adjugate,
// determinant partial products, determinant, sign/magnitude prep, one restoring
// divider stage per quotient bit (DATA_WIDTH+1 of them, nine lanes), saturation.
// Each stage holds under back-pressure only while the stage after it is full,
// so bubbles collapse and input is taken while a result waits.
// Reset clears the valid bits only.
`include "matrix3_inverse_macros.svh"

module matrix3_inverse #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // a11, a12, a13, a21, a22, a23, a31, a32, a33
  input  logic [((mi3_pkg::NUM_ENTRIES*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // b11, b12, b13, b21, b22, b23, b31, b32, b33
  output logic [((mi3_pkg::NUM_ENTRIES*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular, overflowed
  output logic [mi3_pkg::USER_WIDTH-1:0] m_axis_tuser
);
  import mi3_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int N   = NUM_ENTRIES;
  localparam int PW  = 2*W;
  localparam int AW  = 2*W+1;
  localparam int DW  = 3*W+3;
  localparam int IW  = W+2*F;
  localparam int NMW = AW+2*F;
  localparam int RW  = ((DW > IW) ? DW : IW) + 1;
  localparam int QW  = W+1;
  localparam int ND  = W+1;
  localparam int NS  = ND+6;
  localparam int TDW = ((N*W+7)/8)*8;
  localparam int ST_PREP = 4;
  localparam int ST_OUT  = NS-1;

  // ---------------- handshake chain ----------------
  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] en;

  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int k = NS-1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    vin[0] = s_axis_tvalid;
    for (int k = 1; k < NS; k++) begin
      vin[k] = v_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      en[k]  = rdy[k] && vin[k];
      v_d[k] = rdy[k] ? vin[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[ST_OUT];

  // ---------------- stage 0: cofactor products ----------------
  logic signed [W-1:0]  a_in [N];
  logic signed [PW-1:0] pp_q [N];
  logic signed [PW-1:0] pm_q [N];
  logic signed [W-1:0]  r0_q [NUM_COLS];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      a_in[i] = s_axis_tdata[i*W +: W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < N; i++) begin
        pp_q[i] <= a_in[ADJ_PA[i]] * a_in[ADJ_PB[i]];
        pm_q[i] <= a_in[ADJ_QA[i]] * a_in[ADJ_QB[i]];
      end
      for (int j = 0; j < NUM_COLS; j++) begin
        r0_q[j] <= a_in[j];
      end
    end
  end

  // ---------------- stage 1: adjugate ----------------
  logic signed [AW-1:0] adj1_q [N];
  logic signed [W-1:0]  r1_q   [NUM_COLS];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < N; i++) begin
        adj1_q[i] <= AW'(pp_q[i]) - AW'(pm_q[i]);
      end
      r1_q <= r0_q;
    end
  end

  // ---------------- stage 2: determinant partial products ----------------
  logic signed [AW-1:0] adj2_q [N];
  logic signed [AW-1:0] pl_q   [NUM_COLS];
  logic signed [AW-1:0] ph_q   [NUM_COLS];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int j = 0; j < NUM_COLS; j++) begin
        pl_q[j] <= r1_q[j] * $signed({1'b0, adj1_q[j*NUM_COLS][W-1:0]});
        ph_q[j] <= r1_q[j] * $signed(adj1_q[j*NUM_COLS][AW-1:W]);
      end
      adj2_q <= adj1_q;
    end
  end

  // ---------------- stage 3: determinant ----------------
  logic signed [AW-1:0] adj3_q [N];
  logic signed [DW-1:0] det_q;
  logic signed [DW-1:0] det_d;

  always_comb begin
    det_d = '0;
    for (int j = 0; j < NUM_COLS; j++) begin
      det_d = det_d + (DW'(ph_q[j]) <<< W) + DW'(pl_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      det_q  <= det_d;
      adj3_q <= adj2_q;
    end
  end

  // ---------------- stage 4 and divider stages ----------------
  // index 0 is the prep stage, index j the j-th quotient bit
  logic [DW-1:0] dm_q   [ND+1];
  logic          sg_q   [ND+1];
  logic [RW-1:0] rem_q  [ND+1][N];
  logic [QW-1:0] quo_q  [ND+1][N];
  logic [QW-1:0] nlo_q  [ND+1][N];
  logic          rneg_q [ND+1][N];
  logic          big_q  [ND+1][N];

  logic [DW-1:0]  dmag;
  logic [AW-1:0]  amag [N];
  logic [NMW-1:0] num  [N];
  logic [RW-1:0]  rem0 [N];

  always_comb begin
    dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    for (int i = 0; i < N; i++) begin
      amag[i] = adj3_q[i][AW-1] ? AW'(-adj3_q[i]) : AW'(adj3_q[i]);
      num[i]  = {amag[i], {(2*F){1'b0}}};
      rem0[i] = RW'(num[i][NMW-1:QW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_PREP]) begin
      dm_q[0] <= dmag;
      sg_q[0] <= (dmag == '0);
      for (int i = 0; i < N; i++) begin
        rem_q[0][i]  <= rem0[i];
        quo_q[0][i]  <= '0;
        nlo_q[0][i]  <= num[i][QW-1:0];
        rneg_q[0][i] <= adj3_q[i][AW-1] ^ det_q[DW-1];
        // quotient would need more than QW bits
        big_q[0][i]  <= (rem0[i] >= RW'(dmag));
      end
    end
  end

  for (genvar j = 1; j <= ND; j++) begin : g_div
    logic [RW-1:0] shf [N];
    logic          ge  [N];

    always_comb begin
      for (int i = 0; i < N; i++) begin
        shf[i] = {rem_q[j-1][i][RW-2:0], nlo_q[j-1][i][QW-1]};
        ge[i]  = (shf[i] >= RW'(dm_q[j-1]));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_PREP+j]) begin
        dm_q[j] <= dm_q[j-1];
        sg_q[j] <= sg_q[j-1];
        for (int i = 0; i < N; i++) begin
          rem_q[j][i]  <= ge[i] ? RW'(shf[i] - RW'(dm_q[j-1])) : shf[i];
          quo_q[j][i]  <= {quo_q[j-1][i][QW-2:0], ge[i]};
          nlo_q[j][i]  <= {nlo_q[j-1][i][QW-2:0], 1'b0};
          rneg_q[j][i] <= rneg_q[j-1][i];
          big_q[j][i]  <= big_q[j-1][i];
        end
      end
    end
  end

  // ---------------- output stage: saturate ----------------
  localparam logic [QW-1:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

  logic [TDW-1:0] tdata_d, tdata_q;
  logic           sing_q, ovf_q, ovf_d;
  logic [QW-1:0]  lim  [N];
  logic [QW-1:0]  qsat [N];
  logic [QW-1:0]  qval [N];
  logic           sat  [N];

  always_comb begin
    tdata_d = '0;
    ovf_d   = 1'b0;
    for (int i = 0; i < N; i++) begin
      lim[i]  = rneg_q[ND][i] ? LIM_NEG : LIM_POS;
      sat[i]  = big_q[ND][i] || (quo_q[ND][i] > lim[i]);
      qsat[i] = sat[i] ? lim[i] : quo_q[ND][i];
      qval[i] = rneg_q[ND][i] ? QW'(-qsat[i]) : qsat[i];
      if (!sg_q[ND]) begin
        tdata_d[i*W +: W] = qval[i][W-1:0];
        ovf_d = ovf_d | sat[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      tdata_q <= tdata_d;
      sing_q  <= sg_q[ND];
      ovf_q   <= ovf_d;
    end
  end

  assign m_axis_tdata = tdata_q;
  always_comb begin
    m_axis_tuser                = '0;
    m_axis_tuser[USER_SINGULAR] = sing_q;
    m_axis_tuser[USER_OVF]      = ovf_q;
  end

  // ---------------- checks ----------------
  `MI3_ASSERT_IMP(a_take_fills, s_axis_tvalid && s_axis_tready, ##1 v_q[0])
  `MI3_ASSERT_IMP(a_sing_no_ovf, m_axis_tvalid && m_axis_tuser[USER_SINGULAR], !m_axis_tuser[USER_OVF])
  `MI3_ASSERT_IMP(a_sing_zero, m_axis_tvalid && m_axis_tuser[USER_SINGULAR], m_axis_tdata == '0)
  `MI3_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(tdata_q)))

endmodule

// ===== tb/mi3_checker.sv =====
`timescale 1ns / 100ps

module mi3_checker #(
  parameter int DW = 32,
  parameter int FB = 16,
  parameter int TW = 288
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tready_i,
  input  logic [TW-1:0] s_tdata_i,
  input  logic          m_tvalid_i,
  input  logic          m_tready_i,
  input  logic [TW-1:0] m_tdata_i,
  input  logic [mi3_pkg::USER_WIDTH-1:0] m_tuser_i,
  output int            errors_o,
  output int            pending_o,
  output int            results_o,
  output int            singular_seen_o,
  output int            ovf_seen_o
);
  import mi3_pkg::*;

  typedef struct packed {
    logic [TW-1:0] entries;
    logic          singular;
    logic          ovf;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic inverse_t invert_matrix(logic [TW-1:0] mat);
    logic signed [255:0] a [NUM_ENTRIES];
    logic signed [255:0] adj [NUM_ENTRIES];
    logic signed [255:0] det, dmag, num, quo, lim;
    logic                rneg;
    inverse_t            res;
    res = '0;
    for (int i = 0; i < NUM_ENTRIES; i++)
      a[i] = 256'(signed'(mat[i*DW +: DW]));
    adj[0] = a[4]*a[8] - a[5]*a[7];
    adj[1] = a[2]*a[7] - a[1]*a[8];
    adj[2] = a[1]*a[5] - a[2]*a[4];
    adj[3] = a[5]*a[6] - a[3]*a[8];
    adj[4] = a[0]*a[8] - a[2]*a[6];
    adj[5] = a[2]*a[3] - a[0]*a[5];
    adj[6] = a[3]*a[7] - a[4]*a[6];
    adj[7] = a[1]*a[6] - a[0]*a[7];
    adj[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      rneg = (adj[i] < 0) != (det < 0);
      num  = (adj[i] < 0 ? -adj[i] : adj[i]) <<< (2*FB);
      quo  = num / dmag;
      lim  = rneg ? (256'sd1 <<< (DW-1)) : ((256'sd1 <<< (DW-1)) - 1);
      if (quo > lim) begin
        quo = lim;
        res.ovf = 1'b1;
      end
      if (rneg) quo = -quo;
      res.entries[i*DW +: DW] = quo[DW-1:0];
    end
    return res;
  endfunction

  initial begin
    errors_o = 0;
    pending_o = 0;
    results_o = 0;
    singular_seen_o = 0;
    ovf_seen_o = 0;
  end

  always @(posedge clk_i) begin
    inverse_t exp_r;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) inverse_q.push_back(invert_matrix(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        results_o++;
        if (m_tuser_i[USER_SINGULAR]) singular_seen_o++;
        if (m_tuser_i[USER_OVF]) ovf_seen_o++;
        if (inverse_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result transaction %h", $time, m_tdata_i);
        end else begin
          exp_r = inverse_q.pop_front();
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (m_tdata_i[i*DW +: DW] !== exp_r.entries[i*DW +: DW]) begin
              errors_o++;
              $display("%0t: entry %0d expected %h actual %h", $time, i,
                       exp_r.entries[i*DW +: DW], m_tdata_i[i*DW +: DW]);
            end
          if (m_tuser_i[USER_SINGULAR] !== exp_r.singular) begin
            errors_o++;
            $display("%0t: singular expected %b actual %b", $time, exp_r.singular,
                     m_tuser_i[USER_SINGULAR]);
          end
          if (m_tuser_i[USER_OVF] !== exp_r.ovf) begin
            errors_o++;
            $display("%0t: overflowed expected %b actual %b", $time, exp_r.ovf,
                     m_tuser_i[USER_OVF]);
          end
        end
      end
      pending_o = inverse_q.size();
    end
  end
endmodule

// ===== tb/tb_matrix3_inverse.sv =====
`timescale 1ns / 100ps

module tb_matrix3_inverse;
  import mi3_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int TW = ((NUM_ENTRIES*DW+7)/8)*8;
  localparam int LATENCY = DW + 7;
  localparam int RANDOM_ITEMS = 700;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [DW-1:0] ONE = 1 << FRAC_BITS_DEF;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  logic          clk_i, rst_ni;
  logic          s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [TW-1:0] s_axis_tdata, m_axis_tdata;
  logic [USER_WIDTH-1:0] m_axis_tuser;
  int            errors, pending, results, n_sing, n_ovf;
  bit            calm, sent_all, hold_off;
  longint        cycles;

  matrix3_inverse uut (.*);

  mi3_checker #(.DW(DW), .FB(FRAC_BITS_DEF), .TW(TW)) chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .errors_o(errors), .pending_o(pending),
    .results_o(results), .singular_seen_o(n_sing), .ovf_seen_o(n_ovf)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [TW-1:0] pack_matrix(logic [DW-1:0] e [NUM_ENTRIES]);
    logic [TW-1:0] d;
    d = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) d[i*DW +: DW] = e[i];
    return d;
  endfunction

  function automatic logic [DW-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return {$urandom()};
      1: return DW'(signed'($urandom_range(0, 8 << FRAC_BITS_DEF)) -
                   signed'(4 << FRAC_BITS_DEF));
      2: return DW'(signed'($urandom_range(0, 512)) - 256);
      3: return $urandom_range(0, 1) ? MAXV : MINV;
      4: return ONE * DW'($urandom_range(0, 6)) - ONE * 3;
      default: return {$urandom()} >> $urandom_range(0, DW-1);
    endcase
  endfunction

  // offer one matrix and hold it until the block takes it
  task automatic send_matrix(logic [TW-1:0] d);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [DW-1:0] e [NUM_ENTRIES];
    logic [DW-1:0] edge_v [6];
    int            settle;
    edge_v = '{MAXV, MINV, 0, {DW{1'b1}}, ONE, 1};
    calm = 1'b0;
    sent_all = 1'b0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // identity, scaled identity, all-zero and rank-deficient matrices
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    send_matrix(pack_matrix(e));
    e = '{ONE*2, 0, 0, 0, ONE*4, 0, 0, 0, ONE*8};
    send_matrix(pack_matrix(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(pack_matrix(e));
    e = '{ONE, ONE*2, ONE*3, ONE*2, ONE*4, ONE*6, ONE, 0, ONE};
    send_matrix(pack_matrix(e));
    // tiny determinant forces saturation both ways
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(pack_matrix(e));
    e = '{{DW{1'b1}}, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(pack_matrix(e));
    // extremes of the field range on the diagonal and everywhere
    for (int k = 0; k < 6; k++) begin
      e = '{edge_v[k], 0, 0, 0, edge_v[(k+1)%6], 0, 0, 0, edge_v[(k+2)%6]};
      send_matrix(pack_matrix(e));
    end
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < NUM_ENTRIES; i++) e[i] = edge_v[(k+i)%6];
      send_matrix(pack_matrix(e));
    end
    e = '{MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV};
    send_matrix(pack_matrix(e));
    e = '{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE};
    send_matrix(pack_matrix(e));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_off = 1'b1;
      if (n == RANDOM_ITEMS - 100) calm = 1'b1;
      for (int i = 0; i < NUM_ENTRIES; i++) e[i] = rand_entry();
      // some matrices made singular by a repeated row
      if ($urandom_range(0, 9) == 0) begin
        e[6] = e[0];
        e[7] = e[1];
        e[8] = e[2];
      end
      send_matrix(pack_matrix(e));
    end
    s_axis_tvalid <= 1'b0;
    sent_all = 1'b1;

    while (pending != 0) @(negedge clk_i);
    settle = 0;
    while (settle < 2*LATENCY) begin
      @(negedge clk_i);
      settle++;
    end
    $display("tb: %0d inverses checked, %0d singular, %0d saturated", results, n_sing, n_ovf);
    $display("tb: directed extremes, random matrices, stalls and a long output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== matrix3_inverse.f =====
+incdir+design
design/mi3_pkg.sv
design/matrix3_inverse.sv
tb/mi3_checker.sv
tb/tb_matrix3_inverse.sv
